// ----- rtl/cbff_pkg.sv -----
// shared types and constants for the counted bitmap with find-first searches
// no dependencies; used by cbff_ctrl, cbff_dp and the top level
package cbff_pkg;

	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned BIT_W     = 6;
	localparam int unsigned NBITS_DEF = 1024;
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned SIZE_W    = 11;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [REQ_W-1:0] {
		REQ_TEST       = 3'd0,
		REQ_SET        = 3'd1,
		REQ_CLR        = 3'd2,
		REQ_CLR_ALL    = 3'd3,
		REQ_FIRST_SET  = 3'd4,
		REQ_FIRST_CLR  = 3'd5,
		REQ_NEXT_SET   = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_BIT_RD,
		ST_BIT_WR,
		ST_CLR,
		ST_SCAN
	} state_t;

	typedef enum logic [2:0] {
		RSP_NONE,
		RSP_PLAIN,
		RSP_ERR,
		RSP_BIT,
		RSP_HIT,
		RSP_MISS
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic sweep;
		logic rd_bit;
		logic wr_bit;
		logic scan;
		rsp_t rsp;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic clr_last;
		logic scan_hit;
		logic scan_end;
	} dp_sts_t;

endpackage

// ----- rtl/counted_bitmap_find_first_core.sv -----
// Counted bitmap with find-first searches.
// A request (req_type, bit_index) transfers at a rising edge with start high and busy low.
// Each request gives one result, shown for exactly one cycle with done high; the
// receiver cannot hold results off. size_in_use is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle (the block does not enforce this);
// it takes effect on the next request. Steps per request kind:
//   test, set, clear: word read, then write back and result
//   out-of-range index or unused code: result straight from idle, no memory access
//   clear all: one memory word zeroed per cycle
//   searches: one word fetched per cycle, checked the cycle after, until a word holds
//   the answer or no word is left below the map end and the size limit
// Throughput is one request per result: busy stays high until the done cycle (it does
// not rise for range errors or unused codes); a new request may transfer in the done cycle.
// After reset the word memory is cleared by the same sweep as clear all, with busy high;
// configuration writes are still taken during that sweep.
// Depends on cbff_pkg, cbff_ctrl and cbff_dp.
module counted_bitmap_find_first_core #(
	parameter int unsigned NBITS = cbff_pkg::NBITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cbff_pkg::REQ_W-1:0]    req_type,
	input  logic [cbff_pkg::IDX_W-1:0]    bit_index,
	input  logic                          cfg_we,
	input  logic [cbff_pkg::SIZE_W-1:0]   cfg_wdata,
	output logic                          done,
	output logic                          bit_value,
	output logic                          found,
	output logic [cbff_pkg::IDX_W-1:0]    found_index,
	output logic [cbff_pkg::CNT_W-1:0]    set_count,
	output logic                          range_error
);
	import cbff_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	cbff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	cbff_dp #(
		.NBITS (NBITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.bit_index   (bit_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.bit_value   (bit_value),
		.found       (found),
		.found_index (found_index),
		.set_count   (set_count),
		.range_error (range_error)
	);

endmodule

// ----- rtl/cbff_ctrl.sv -----
// controller state machine: request decode, clearing sweep, bit access and scan sequencing
// depends on cbff_pkg; drives cbff_dp through dp_cmd_t and reads dp_sts_t
module cbff_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cbff_pkg::REQ_W-1:0]   req_type,
	input  cbff_pkg::dp_sts_t            sts,
	output cbff_pkg::dp_cmd_t            cmd,
	output logic                         busy
);
	import cbff_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rsp = RSP_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					unique case (req_t'(req_type))
						REQ_TEST, REQ_SET, REQ_CLR: begin
							if (sts.in_range) begin
								state_d = ST_BIT_RD;
							end else begin
								cmd.rsp = RSP_ERR;
							end
						end
						REQ_CLR_ALL: begin
							state_d = ST_CLR;
						end
						REQ_FIRST_SET, REQ_FIRST_CLR: begin
							state_d = ST_SCAN;
						end
						REQ_NEXT_SET: begin
							if (sts.in_range) begin
								state_d = ST_SCAN;
							end else begin
								cmd.rsp = RSP_ERR;
							end
						end
						default: begin
							// unused code: count only
							cmd.rsp = RSP_PLAIN;
						end
					endcase
				end
			end
			ST_BIT_RD: begin
				cmd.rd_bit = 1'b1;
				state_d    = ST_BIT_WR;
			end
			ST_BIT_WR: begin
				cmd.wr_bit = 1'b1;
				cmd.rsp    = RSP_BIT;
				state_d    = ST_IDLE;
			end
			ST_CLR: begin
				cmd.sweep = 1'b1;
				if (sts.clr_last) begin
					cmd.rsp = RSP_PLAIN;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					cmd.rsp = RSP_HIT;
					state_d = ST_IDLE;
				end else if (sts.scan_end) begin
					cmd.rsp = RSP_MISS;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/cbff_dp.sv -----
// datapath: word memory, set-bit counter, size register, word scanner and result registers
// depends on cbff_pkg; sequenced by cbff_ctrl
module cbff_dp #(
	parameter int unsigned NBITS = cbff_pkg::NBITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbff_pkg::dp_cmd_t             cmd,
	output cbff_pkg::dp_sts_t             sts,
	input  logic [cbff_pkg::REQ_W-1:0]    req_type,
	input  logic [cbff_pkg::IDX_W-1:0]    bit_index,
	input  logic                          cfg_we,
	input  logic [cbff_pkg::SIZE_W-1:0]   cfg_wdata,
	output logic                          done,
	output logic                          bit_value,
	output logic                          found,
	output logic [cbff_pkg::IDX_W-1:0]    found_index,
	output logic [cbff_pkg::CNT_W-1:0]    set_count,
	output logic                          range_error
);
	import cbff_pkg::*;

	localparam int unsigned NWORDS   = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int unsigned PW       = $clog2(NWORDS + 1);
	localparam int unsigned CW       = (PW + BIT_W > SIZE_W) ? PW + BIT_W : SIZE_W;
	localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;
	localparam int unsigned CAP      = (NBITS > SIZE_MAX) ? SIZE_MAX : NBITS;
	localparam logic [WORD_BITS-1:0] ONES = '1;

	logic [WORD_BITS-1:0] mem [NWORDS];

	logic [SIZE_W-1:0]    size_q;
	logic [SIZE_W-1:0]    eff;
	req_t                 req_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 want_q;
	logic [SIZE_W-1:0]    start_q;
	logic [SIZE_W-1:0]    start_d;
	logic [PW-1:0]        rptr_q;
	logic [PW-1:0]        eptr_s1;
	logic                 ev_s1;
	logic [WORD_BITS-1:0] rdata_q;
	logic [WW-1:0]        clr_ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_d;

	logic                 issue;
	logic                 rd_en;
	logic [WW-1:0]        raddr;
	logic [WW-1:0]        bit_addr;
	logic                 we;
	logic [WW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] bmask;
	logic                 was;
	logic                 do_set;
	logic                 do_clr;

	logic [WORD_BITS-1:0] word_v;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] masked;
	logic [BIT_W-1:0]     pos;
	logic                 hit;
	logic [IDX_W-1:0]     fidx;

	assign eff = (size_q > SIZE_W'(CAP)) ? SIZE_W'(CAP) : size_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	assign start_d = (req_type == REQ_NEXT_SET) ? (SIZE_W'(bit_index) + SIZE_W'(1)) : '0;

	// request latch and scan pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= REQ_TEST;
			idx_q   <= '0;
			want_q  <= 1'b0;
			start_q <= '0;
			rptr_q  <= '0;
			eptr_s1 <= '0;
			ev_s1   <= 1'b0;
		end else begin
			ev_s1 <= cmd.scan && issue;
			if (cmd.latch) begin
				req_q   <= req_t'(req_type);
				idx_q   <= bit_index;
				want_q  <= (req_type != REQ_FIRST_CLR);
				start_q <= start_d;
				rptr_q  <= PW'(start_d >> BIT_W);
			end else if (cmd.scan && issue) begin
				rptr_q  <= rptr_q + PW'(1);
				eptr_s1 <= rptr_q;
			end
		end
	end

	// a word is fetched while it is below the map end and below the size limit
	assign issue = (32'(rptr_q) < NWORDS) && (CW'({rptr_q, BIT_W'(0)}) < CW'(eff));

	assign bit_addr = WW'(idx_q >> BIT_W);
	assign raddr    = cmd.scan ? WW'(rptr_q) : bit_addr;
	assign rd_en    = cmd.rd_bit || (cmd.scan && issue);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// read-modify-write of one bit
	assign bmask  = WORD_BITS'(1) << idx_q[BIT_W-1:0];
	assign was    = rdata_q[idx_q[BIT_W-1:0]];
	assign do_set = cmd.wr_bit && (req_q == REQ_SET) && !was;
	assign do_clr = cmd.wr_bit && (req_q == REQ_CLR) && was;

	assign we    = cmd.sweep || do_set || do_clr;
	assign waddr = cmd.sweep ? clr_ptr_q : bit_addr;
	always_comb begin
		if (cmd.sweep) begin
			wdata = '0;
		end else if (do_set) begin
			wdata = rdata_q | bmask;
		end else begin
			wdata = rdata_q & ~bmask;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.sweep) begin
			clr_ptr_q <= sts.clr_last ? '0 : clr_ptr_q + WW'(1);
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.sweep) begin
			cnt_d = '0;
		end else if (do_set) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (do_clr) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// word evaluation: trim below the start bit and at or above the size limit
	always_comb begin
		word_v  = want_q ? rdata_q : ~rdata_q;
		lo_mask = ONES;
		hi_mask = ONES;
		if (CW'(eptr_s1) == CW'(start_q >> BIT_W)) begin
			lo_mask = ONES << start_q[BIT_W-1:0];
		end
		if (CW'(eptr_s1) == CW'(eff >> BIT_W)) begin
			hi_mask = ~(ONES << eff[BIT_W-1:0]);
		end
		masked = word_v & lo_mask & hi_mask;
	end

	// lowest set position
	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (masked[b]) begin
				pos = BIT_W'(b);
			end
		end
	end

	assign hit  = ev_s1 && (masked != '0);
	assign fidx = IDX_W'({eptr_s1, pos});

	assign sts.in_range = ({1'b0, bit_index} < eff);
	assign sts.clr_last = (clr_ptr_q == WW'(NWORDS - 1));
	assign sts.scan_hit = hit;
	assign sts.scan_end = !issue && !hit;

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			bit_value   <= 1'b0;
			found       <= 1'b0;
			found_index <= '0;
			set_count   <= '0;
			range_error <= 1'b0;
		end else begin
			done <= (cmd.rsp != RSP_NONE);
			if (cmd.rsp != RSP_NONE) begin
				bit_value   <= (cmd.rsp == RSP_BIT) && was;
				found       <= (cmd.rsp == RSP_HIT);
				found_index <= (cmd.rsp == RSP_HIT) ? fidx : '0;
				set_count   <= cnt_d;
				range_error <= (cmd.rsp == RSP_ERR);
			end
		end
	end

endmodule

// ----- rtl/cbff_chk.sv -----
// port-level checker for the counted bitmap core, attached by bind
// depends on cbff_pkg and counted_bitmap_find_first_core
module cbff_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          bit_value,
	input logic                          found,
	input logic [cbff_pkg::IDX_W-1:0]    found_index
	,
	input logic                          range_error
);
	import cbff_pkg::*;

	// an accepted request is either answered next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("request transfer neither answered nor busy");

	// every result follows an accepted request or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $past(busy))
		else $error("result without a request");

	// a range error changes nothing and reports nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> !found && !bit_value && (found_index == '0))
		else $error("range error with other result bits");

	// index is zero unless a search found a bit
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> (found_index == '0))
		else $error("found_index nonzero without found");

endmodule

bind counted_bitmap_find_first_core cbff_chk u_cbff_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.bit_value   (bit_value),
	.found       (found),
	.found_index (found_index),
	.range_error (range_error)
);

// ----- test/cbff_checker.sv -----
// result checker for counted_bitmap_find_first_core: keeps its own copy of the bitmap,
// the set-bit count and the size register, predicts each result and compares it
// depends on cbff_pkg only
module cbff_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [cbff_pkg::REQ_W-1:0]    req_type,
	input  logic [cbff_pkg::IDX_W-1:0]    bit_index,
	input  logic                          cfg_we,
	input  logic [cbff_pkg::SIZE_W-1:0]   cfg_wdata,
	input  logic                          done,
	input  logic                          bit_value,
	input  logic                          found,
	input  logic [cbff_pkg::IDX_W-1:0]    found_index,
	input  logic [cbff_pkg::CNT_W-1:0]    set_count,
	input  logic                          range_error,
	output int                            mismatches,
	output int                            outstanding,
	output int                            checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import cbff_pkg::*;

	localparam int unsigned MAP_BITS = NBITS_DEF;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic             bit_value;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] set_count;
		logic             range_error;
	} map_result_t;

	logic [MAP_BITS-1:0] bitmap;
	int unsigned         ones_total;
	logic [SIZE_W-1:0]   size_reg;
	map_result_t         expected_q[$];
	map_result_t         want;
	map_result_t         got;

	initial begin
		mismatches = 0;
		checked = 0;
		outstanding = 0;
	end

	// lowest index in [from, lim) whose bit equals want_bit
	function automatic logic scan_for(input int unsigned from, input logic want_bit,
			input int unsigned lim, output logic [IDX_W-1:0] pos);
		pos = '0;
		for (int unsigned i = from; i < lim; i++) begin
			if (bitmap[i] == want_bit) begin
				pos = IDX_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic map_result_t apply_request(input logic [REQ_W-1:0] rt,
			input logic [IDX_W-1:0] idx);
		map_result_t r;
		int unsigned lim;
		logic hit;
		logic [IDX_W-1:0] pos;
		r = '0;
		hit = 1'b0;
		pos = '0;
		// sizes above the map saturate
		lim = (size_reg > MAP_BITS) ? MAP_BITS : size_reg;
		case (rt)
			REQ_TEST, REQ_SET, REQ_CLR: begin
				if (idx >= lim) begin
					r.range_error = 1'b1;
				end else begin
					r.bit_value = bitmap[idx];
					if (rt == REQ_SET && !bitmap[idx]) begin
						bitmap[idx] = 1'b1;
						ones_total++;
					end else if (rt == REQ_CLR && bitmap[idx]) begin
						bitmap[idx] = 1'b0;
						ones_total--;
					end
				end
			end
			REQ_CLR_ALL: begin
				bitmap = '0;
				ones_total = 0;
			end
			REQ_FIRST_SET: begin
				hit = scan_for(0, 1'b1, lim, pos);
			end
			REQ_FIRST_CLR: begin
				hit = scan_for(0, 1'b0, lim, pos);
			end
			REQ_NEXT_SET: begin
				if (idx >= lim)
					r.range_error = 1'b1;
				else
					hit = scan_for(int'(idx) + 1, 1'b1, lim, pos);
			end
			default: begin
			end
		endcase
		r.found = hit;
		r.found_index = hit ? pos : '0;
		r.set_count = CNT_W'(ones_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap = '0;
			ones_total = 0;
			size_reg = SIZE_RESET;
			expected_q.delete();
			outstanding <= 0;
		end else begin
			// a result may leave in the same cycle that the next request transfers
			if (done) begin
				got = '{bit_value, found, found_index, set_count, range_error};
				if (expected_q.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("[%0t] result with no request pending: %s",
							$realtime, $sformatf("bv=%0b f=%0b idx=%0d cnt=%0d err=%0b",
							got.bit_value, got.found, got.found_index,
							got.set_count, got.range_error));
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (mismatches < REPORT_MAX) begin
							$display("[%0t] result %0d differs:", $realtime, checked);
							$display("  expected bv=%0b f=%0b idx=%0d cnt=%0d err=%0b",
								want.bit_value, want.found, want.found_index,
								want.set_count, want.range_error);
							$display("  got      bv=%0b f=%0b idx=%0d cnt=%0d err=%0b",
								got.bit_value, got.found, got.found_index,
								got.set_count, got.range_error);
						end
						mismatches++;
					end
					checked++;
				end
			end
			if (start && !busy)
				expected_q.push_back(apply_request(req_type, bit_index));
			if (cfg_we)
				size_reg = cfg_wdata;
			outstanding <= expected_q.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
// top of the bench for counted_bitmap_find_first_core: clock, reset, request and size stimulus
// and the verdict; prediction and comparison live in cbff_checker
// depends on cbff_pkg, cbff_checker and the core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cbff_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
	localparam int unsigned MAP_BITS = NBITS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 125;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [REQ_W-1:0]  req_type = '0;
	logic [IDX_W-1:0]  bit_index = '0;
	logic              cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              busy;
	logic              done;
	logic              bit_value;
	logic              found;
	logic [IDX_W-1:0]  found_index;
	logic [CNT_W-1:0]  set_count;
	logic              range_error;

	int mismatches;
	int outstanding;
	int checked;
	int cycle_count = 0;
	int requests_sent = 0;
	int sizes_used = 0;

	always #5 clk = ~clk;

	counted_bitmap_find_first_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.bit_index   (bit_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.bit_value   (bit_value),
		.found       (found),
		.found_index (found_index),
		.set_count   (set_count),
		.range_error (range_error)
	);

	cbff_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.bit_index   (bit_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.bit_value   (bit_value),
		.found       (found),
		.found_index (found_index),
		.set_count   (set_count),
		.range_error (range_error),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				outstanding);
			$display("** counted_bitmap_find_first_core: FAILED **");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge where the request transfers
	task automatic send_request(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] idx);
		req_type <= rt;
		bit_index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// hold start low with junk on the request fields
	task automatic hold_off(input int n);
		start <= 1'b0;
		req_type <= REQ_W'($urandom);
		bit_index <= IDX_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// only called once the block is idle
	task automatic write_size(input logic [SIZE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= SIZE_W'($urandom);
		sizes_used++;
	endtask

	function automatic logic [REQ_W-1:0] pick_req(input logic fill_heavy);
		int r;
		r = $urandom_range(0, 99);
		if (fill_heavy) begin
			if (r < 55) return REQ_SET;
			if (r < 65) return REQ_TEST;
			if (r < 70) return REQ_CLR;
			if (r < 78) return REQ_FIRST_SET;
			if (r < 90) return REQ_FIRST_CLR;
			if (r < 98) return REQ_NEXT_SET;
			if (r < 99) return REQ_CLR_ALL;
			return REQ_UNUSED;
		end
		if (r < 25) return REQ_SET;
		if (r < 40) return REQ_TEST;
		if (r < 55) return REQ_CLR;
		if (r < 65) return REQ_FIRST_SET;
		if (r < 75) return REQ_FIRST_CLR;
		if (r < 93) return REQ_NEXT_SET;
		if (r < 96) return REQ_CLR_ALL;
		return REQ_UNUSED;
	endfunction

	// mostly in range, some at the edges, some anywhere in the field
	function automatic logic [IDX_W-1:0] pick_index(input int unsigned lim);
		int r;
		r = $urandom_range(0, 99);
		if (lim == 0 || r < 8)
			return IDX_W'($urandom_range(0, MAP_BITS - 1));
		if (r < 12)
			return '0;
		if (r < 17)
			return IDX_W'(lim - 1);
		if (r < 20 && lim < MAP_BITS)
			return IDX_W'(lim);
		return IDX_W'($urandom_range(0, lim - 1));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic run_phase(input logic [SIZE_W-1:0] size, input logic fill_heavy);
		int unsigned lim;
		int gap;
		wait_quiet();
		write_size(size);
		lim = (size > MAP_BITS) ? MAP_BITS : size;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send_request(pick_req(fill_heavy), pick_index(lim));
			// back-to-back stretch at the start of every 50 transfers
			gap = (i % 50 < 15) ? 0 : pick_gap();
			if (gap > 0)
				hold_off(gap);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, then the corner sizes
		send_request(REQ_TEST, 10'd0);
		send_request(REQ_SET, 10'd0);
		send_request(REQ_SET, 10'd1023);
		send_request(REQ_TEST, 10'd1023);
		send_request(REQ_FIRST_SET, 10'd512);
		send_request(REQ_NEXT_SET, 10'd0);
		// next set from the last valid bit finds nothing without an error
		send_request(REQ_NEXT_SET, 10'd1023);
		send_request(REQ_FIRST_CLR, 10'd0);
		send_request(REQ_CLR, 10'd0);
		send_request(REQ_CLR, 10'd0);
		send_request(REQ_UNUSED, 10'd1023);
		send_request(REQ_SET, 10'd900);
		send_request(REQ_CLR_ALL, 10'd0);
		send_request(REQ_FIRST_SET, 10'd0);
		wait_quiet();
		// empty map: every indexed request is out of range
		write_size(11'd0);
		send_request(REQ_TEST, 10'd0);
		send_request(REQ_FIRST_SET, 10'd0);
		send_request(REQ_NEXT_SET, 10'd0);
		send_request(REQ_FIRST_CLR, 10'd0);
		wait_quiet();
		// single-bit map, filled completely
		write_size(11'd1);
		send_request(REQ_SET, 10'd0);
		send_request(REQ_FIRST_CLR, 10'd0);
		send_request(REQ_SET, 10'd1);
		wait_quiet();
		// size beyond the map saturates
		write_size(11'd2047);
		send_request(REQ_SET, 10'd1023);
		wait_quiet();
		// shrink below a set bit: still counted, no longer searched
		write_size(11'd64);
		send_request(REQ_FIRST_SET, 10'd0);
		send_request(REQ_NEXT_SET, 10'd0);
		send_request(REQ_TEST, 10'd64);

		run_phase(11'd1024, 1'b0);
		run_phase(11'd64, 1'b1);
		run_phase(11'd1, 1'b0);
		run_phase(11'd2047, 1'b0);
		run_phase(11'd0, 1'b0);
		run_phase(11'd130, 1'b1);
		run_phase(SIZE_W'($urandom_range(1, MAP_BITS)), 1'b0);
		run_phase(11'd65, 1'b1);
		run_phase(SIZE_W'($urandom_range(0, 2047)), 1'b0);
		run_phase(11'd1024, 1'b1);

		wait_quiet();
		repeat (40) @(posedge clk);
		$display("covered %0d requests over %0d size settings; %0d results compared",
			requests_sent, sizes_used + 1, checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** counted_bitmap_find_first_core: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, outstanding);
			$display("** counted_bitmap_find_first_core: FAILED **");
		end
		$finish;
	end

endmodule
